// ===== sv/vrp_pkg.sv =====
package vrp_pkg;

    localparam int COMP_COUNT    = 16;
    localparam int WORD_WIDTH    = 32;
    localparam int FORMAT_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int QUEUE_DEPTH   = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEST_FORMAT   = 2'd1;

    // One classified source word, passed from the front to the back
    typedef struct packed {
        logic [WORD_WIDTH-1:0]   word;
        logic [FORMAT_WIDTH-1:0] fill;     // destination-only components to zero fill
        logic                    copy;     // emit the word itself at component comp
        logic [3:0]              comp;
        logic                    done;     // this word closes the vertex
    } vrp_cmd_t;

    // Words per component, in mask bit order
    function automatic logic [1:0] comp_words(input logic [3:0] c);
        logic [1:0] n;
        unique case (c)
            4'd0, 4'd6:                 n = 2'd3;
            4'd10, 4'd11, 4'd12, 4'd13: n = 2'd2;
            default:                    n = 2'd1;
        endcase
        return n;
    endfunction

    // Index of the lowest set bit, 0 for an empty mask
    function automatic logic [3:0] lowest_bit(input logic [FORMAT_WIDTH-1:0] m);
        logic [3:0] b;
        b = 4'd0;
        for (int i = FORMAT_WIDTH - 1; i >= 0; i--) begin
            if (m[i]) begin
                b = 4'(i);
            end
        end
        return b;
    endfunction

    // Bits strictly above component c
    function automatic logic [FORMAT_WIDTH-1:0] above_mask(input logic [3:0] c);
        logic [FORMAT_WIDTH-1:0] m;
        for (int i = 0; i < FORMAT_WIDTH; i++) begin
            m[i] = (i > int'(c));
        end
        return m;
    endfunction

    // Bits in [lo, hi)
    function automatic logic [FORMAT_WIDTH-1:0] range_mask(input logic [4:0] lo,
                                                          input logic [3:0] hi);
        logic [FORMAT_WIDTH-1:0] m;
        for (int i = 0; i < FORMAT_WIDTH; i++) begin
            m[i] = (i >= int'(lo)) && (i < int'(hi));
        end
        return m;
    endfunction

endpackage

// ===== sv/vrp_front.sv =====
module vrp_front
    import vrp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [FORMAT_WIDTH-1:0]  cfg_data,
    input  logic                     source_valid,
    input  logic [WORD_WIDTH-1:0]    source_word,
    input  logic                     queue_ready,
    output logic                     push_valid,
    output vrp_cmd_t                 push_cmd
);

    logic [FORMAT_WIDTH-1:0] src_fmt_reg, dst_fmt_reg;
    logic                    start_reg, start_next;
    logic [3:0]              comp_reg, comp_next;
    logic [1:0]              off_reg, off_next;
    logic [4:0]              gap_reg, gap_next;

    logic                    accept;
    logic                    src_empty;
    logic [3:0]              comp;
    logic [1:0]              off;
    logic [4:0]              gap;
    logic                    last_of_comp;
    logic [FORMAT_WIDTH-1:0] above;
    logic [FORMAT_WIDTH-1:0] dst_only;
    logic [FORMAT_WIDTH-1:0] fill;
    logic                    done;
    logic                    copy;

    assign accept    = source_valid && queue_ready;
    assign src_empty = (src_fmt_reg == '0);
    assign dst_only  = dst_fmt_reg & ~src_fmt_reg;

    // Locate the current word in the source layout
    assign comp         = start_reg ? lowest_bit(src_fmt_reg) : comp_reg;
    assign off          = start_reg ? 2'd0 : off_reg;
    assign gap          = start_reg ? 5'd0 : gap_reg;
    assign last_of_comp = (2'(off + 2'd1) == comp_words(comp));
    assign above        = src_fmt_reg & above_mask(comp);

    // Classify: fills before, own word, fills after the last component
    always_comb
    begin
        if (src_empty)
        begin
            done = 1'b1;
            copy = 1'b0;
            fill = dst_fmt_reg;
        end
        else
        begin
            done = last_of_comp && (above == '0);
            copy = dst_fmt_reg[comp];
            fill = dst_only & (((off == 2'd0) ? range_mask(gap, comp) : '0) |
                               (done ? above_mask(comp) : '0));
        end
    end

    assign push_valid    = accept && ((fill != '0) || copy);
    assign push_cmd.word = source_word;
    assign push_cmd.fill = fill;
    assign push_cmd.copy = copy;
    assign push_cmd.comp = comp;
    assign push_cmd.done = done;

    // Advance the position within the vertex
    always_comb
    begin
        start_next = start_reg;
        comp_next  = comp_reg;
        off_next   = off_reg;
        gap_next   = gap_reg;
        if (cfg_valid && (cfg_index == CFG_SOURCE_FORMAT || cfg_index == CFG_DEST_FORMAT))
        begin
            start_next = 1'b1;
        end
        else if (accept && !src_empty)
        begin
            if (done)
            begin
                start_next = 1'b1;
            end
            else if (last_of_comp)
            begin
                start_next = 1'b0;
                comp_next  = lowest_bit(above);
                off_next   = 2'd0;
                gap_next   = 5'(comp) + 5'd1;
            end
            else
            begin
                start_next = 1'b0;
                comp_next  = comp;
                off_next   = 2'(off + 2'd1);
                gap_next   = gap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= '0;
            dst_fmt_reg <= '0;
            start_reg   <= 1'b1;
            comp_reg    <= '0;
            off_reg     <= '0;
            gap_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_SOURCE_FORMAT)
            begin
                src_fmt_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_DEST_FORMAT)
            begin
                dst_fmt_reg <= cfg_data;
            end
            start_reg <= start_next;
            comp_reg  <= comp_next;
            off_reg   <= off_next;
            gap_reg   <= gap_next;
        end
    end

endmodule

// ===== sv/vrp_queue.sv =====
module vrp_queue
    import vrp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  vrp_cmd_t push_cmd,
    output logic     push_ready,
    output logic     head_valid,
    output vrp_cmd_t head_cmd,
    input  logic     pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vrp_cmd_t             mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/vrp_back.sv =====
module vrp_back
    import vrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  vrp_cmd_t              head_cmd,
    output logic                  pop,
    output logic                  dest_valid,
    input  logic                  dest_stall,
    output logic [WORD_WIDTH-1:0] dest_word,
    output logic                  vertex_end,
    output logic                  run_last
);

    logic                    active_reg, active_next;
    logic [FORMAT_WIDTH-1:0] rem_reg, rem_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    out_valid_reg;
    logic [WORD_WIDTH-1:0]   out_word_reg;
    logic                    out_end_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    emit;
    logic [FORMAT_WIDTH-1:0] eff;
    logic [3:0]              b;
    logic                    is_copy;
    logic                    comp_done;
    logic [FORMAT_WIDTH-1:0] eff_after;
    logic                    last;

    assign out_free = !out_valid_reg || !dest_stall;
    assign emit     = head_valid && out_free;

    // Pick the lowest pending component of the head word
    assign eff       = active_reg ? rem_reg
                     : (head_cmd.fill | (FORMAT_WIDTH'(head_cmd.copy) << head_cmd.comp));
    assign b         = lowest_bit(eff);
    assign is_copy   = head_cmd.copy && (b == head_cmd.comp);
    assign comp_done = is_copy || (2'(cnt_reg + 2'd1) == comp_words(b));
    assign eff_after = comp_done ? (eff & ~(FORMAT_WIDTH'(1) << b)) : eff;
    assign last      = (eff_after == '0);
    assign pop       = emit && last;

    // Step through the run one word at a time
    always_comb
    begin
        active_next = active_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        if (emit)
        begin
            active_next = !last;
            rem_next    = eff_after;
            cnt_next    = comp_done ? 2'd0 : 2'(cnt_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            if (out_free)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    // Hold the output word until taken
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= is_copy ? head_cmd.word : '0;
            out_end_reg  <= last && head_cmd.done;
            out_last_reg <= last;
        end
    end

    assign dest_valid = out_valid_reg;
    assign dest_word  = out_word_reg;
    assign vertex_end = out_end_reg;
    assign run_last   = out_last_reg;

endmodule

// ===== sv/vertex_format_repacker_top.sv =====
// Vertex format repacker: converts a stream of 32-bit vertex words from the
// layout in source_format to the layout in dest_format (16-bit component masks,
// bit i = component i in fixed order). A front stage classifies each source word
// against its position in the vertex, a small command queue (QUEUE_DEPTH entries)
// follows, and a back stage emits the destination words, one word per cycle
// while the receiver does not stall, with zero words for destination-only
// components. A source word is taken every cycle while it yields at most one
// destination word; a word that yields a run of n words (up to 24) holds the
// back stage for the run, and the input stalls once the queue is full. Write
// configuration only while idle; a format register write restarts the vertex.
module vertex_format_repacker_top
    import vrp_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [FORMAT_WIDTH-1:0]  cfg_data,
    input  logic                     source_valid,
    output logic                     source_stall,
    input  logic [WORD_WIDTH-1:0]    source_word,
    output logic                     dest_valid,
    input  logic                     dest_stall,
    output logic [WORD_WIDTH-1:0]    dest_word,
    output logic                     vertex_end,
    output logic                     run_last
);

    logic     queue_ready;
    logic     push_valid;
    vrp_cmd_t push_cmd;
    logic     head_valid;
    vrp_cmd_t head_cmd;
    logic     pop;

    assign cfg_ready    = 1'b1;
    assign source_stall = !queue_ready;

    vrp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_valid (source_valid),
        .source_word  (source_word),
        .queue_ready  (queue_ready),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd)
    );

    vrp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (queue_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    vrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .dest_valid (dest_valid),
        .dest_stall (dest_stall),
        .dest_word  (dest_word),
        .vertex_end (vertex_end),
        .run_last   (run_last)
    );

endmodule

// ===== sv/vrp_checker.sv =====
module vrp_checker
    import vrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  dest_valid,
    input  logic                  dest_stall,
    input  logic [WORD_WIDTH-1:0] dest_word,
    input  logic                  vertex_end,
    input  logic                  run_last
);

    // A stalled output word holds
    a_dest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dest_valid && dest_stall |=> dest_valid && $stable(dest_word)
            && $stable(vertex_end) && $stable(run_last))
        else $error("dest word changed while stalled");

    // A vertex closes only on the last word of a run
    a_end_in_last: assert property (@(posedge clk) disable iff (!rst_n)
        dest_valid && vertex_end |-> run_last)
        else $error("vertex_end without run_last");

    // A run, once started, continues without a bubble
    a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
        dest_valid && !dest_stall && !run_last |=> dest_valid)
        else $error("bubble inside a run");

endmodule

bind vertex_format_repacker_top vrp_checker u_vrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest_word  (dest_word),
    .vertex_end (vertex_end),
    .run_last   (run_last)
);

// ===== sim/vertex_format_repacker_top_test.sv =====
module vertex_format_repacker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vrp_pkg::*;

    // Register indexes past the two format registers; writes there change nothing
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_3 = 2'd3;

    localparam int ITEMS_PER_PHASE = 26;
    localparam int RANDOM_PHASES   = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int SETTLE_CYCLES   = 16;

    // One destination word as it leaves the block
    typedef struct packed {
        logic [WORD_WIDTH-1:0] word;
        logic                  vertex_end;
        logic                  run_last;
    } dest_word_t;

    // Repacks source words into expected destination words and checks the output
    class repack_checker;
        logic [FORMAT_WIDTH-1:0] src_fmt;
        logic [FORMAT_WIDTH-1:0] dst_fmt;
        logic [4:0]              word_pos;
        dest_word_t              run[$];
        dest_word_t              words_due[$];
        int                      errors;
        int                      words_taken;
        int                      words_checked;
        int                      reg_writes;

        function new();
            src_fmt       = '0;
            dst_fmt       = '0;
            word_pos      = '0;
            errors        = 0;
            words_taken   = 0;
            words_checked = 0;
            reg_writes    = 0;
        endfunction

        function int unsigned comp_len(int c);
            case (c)
                0, 6:           return 3;
                10, 11, 12, 13: return 2;
                default:        return 1;
            endcase
        endfunction

        function int unsigned vertex_len(logic [FORMAT_WIDTH-1:0] m);
            int unsigned s;
            s = 0;
            for (int i = 0; i < COMP_COUNT; i++) begin
                if (m[i]) begin
                    s += comp_len(i);
                end
            end
            return s;
        endfunction

        function void write_format(logic [CFG_IDX_WIDTH-1:0] idx, logic [FORMAT_WIDTH-1:0] data);
            reg_writes++;
            if (idx == CFG_SOURCE_FORMAT) begin
                src_fmt  = data;
                word_pos = '0;
            end else if (idx == CFG_DEST_FORMAT) begin
                dst_fmt  = data;
                word_pos = '0;
            end
        endfunction

        // Zero words for destination-only components in [lo, hi)
        function void add_zero_fills(int lo, int hi);
            dest_word_t z;
            z = '{word: '0, vertex_end: 1'b0, run_last: 1'b0};
            for (int d = lo; d < hi && d < COMP_COUNT; d++) begin
                if (dst_fmt[d] && !src_fmt[d]) begin
                    for (int j = 0; j < int'(comp_len(d)); j++) begin
                        run.push_back(z);
                    end
                end
            end
        endfunction

        function void take_source_word(logic [WORD_WIDTH-1:0] w);
            int unsigned size;
            int unsigned p;
            int unsigned acc;
            int unsigned gap;
            int unsigned comp;
            int unsigned off;
            bit          done;
            dest_word_t  c;
            run.delete();
            words_taken++;
            size = vertex_len(src_fmt);
            if (size == 0) begin
                // Empty source: each word stands for a whole vertex of zeros
                add_zero_fills(0, COMP_COUNT);
                word_pos = '0;
                done     = 1'b1;
            end else begin
                p = word_pos;
                if (p >= size) begin
                    p = 0;
                end
                acc  = 0;
                gap  = 0;
                comp = 0;
                off  = 0;
                // Find the source component that holds this word
                for (int i = 0; i < COMP_COUNT; i++) begin
                    if (src_fmt[i]) begin
                        if (p < acc + comp_len(i)) begin
                            comp = i;
                            off  = p - acc;
                            break;
                        end
                        acc += comp_len(i);
                        gap  = i + 1;
                    end
                end
                // Fills ahead of a component go out with its first word
                if (off == 0) begin
                    add_zero_fills(gap, comp);
                end
                if (dst_fmt[comp]) begin
                    c = '{word: w, vertex_end: 1'b0, run_last: 1'b0};
                    run.push_back(c);
                end
                done = (p + 1 == size);
                if (done) begin
                    add_zero_fills(comp + 1, COMP_COUNT);
                    word_pos = '0;
                end else begin
                    word_pos = 5'(p + 1);
                end
            end
            // Mark the tail of the run
            if (run.size() > 0) begin
                c            = run[run.size() - 1];
                c.vertex_end = done;
                c.run_last   = 1'b1;
                run[run.size() - 1] = c;
            end
            foreach (run[k]) begin
                words_due.push_back(run[k]);
            end
        endfunction

        function void check_dest_word(logic [WORD_WIDTH-1:0] w, logic ve, logic rl);
            dest_word_t e;
            words_checked++;
            if (words_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected dest word %h (vertex_end %b, run_last %b)",
                         $time, w, ve, rl);
                return;
            end
            e = words_due.pop_front();
            if (w !== e.word) begin
                errors++;
                $display("%0t: dest_word expected %h, got %h", $time, e.word, w);
            end
            if (ve !== e.vertex_end) begin
                errors++;
                $display("%0t: vertex_end expected %b, got %b", $time, e.vertex_end, ve);
            end
            if (rl !== e.run_last) begin
                errors++;
                $display("%0t: run_last expected %b, got %b", $time, e.run_last, rl);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [FORMAT_WIDTH-1:0]  cfg_data;
    logic                     source_valid;
    logic                     source_stall;
    logic [WORD_WIDTH-1:0]    source_word;
    logic                     dest_valid;
    logic                     dest_stall;
    logic [WORD_WIDTH-1:0]    dest_word;
    logic                     vertex_end;
    logic                     run_last;

    repack_checker chk;
    int            src_idle_pct = 0;
    int            stall_pct    = 0;
    int            hold_req     = 0;
    int            hold_ack     = 0;
    int            hold_left    = 0;

    vertex_format_repacker_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_valid (source_valid),
        .source_stall (source_stall),
        .source_word  (source_word),
        .dest_valid   (dest_valid),
        .dest_stall   (dest_stall),
        .dest_word    (dest_word),
        .vertex_end   (vertex_end),
        .run_last     (run_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drive receiver stall: random, or held high for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_ack != hold_req) begin
            hold_ack   <= hold_req;
            hold_left  <= HOLD_CYCLES;
            dest_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            dest_stall <= 1'b1;
        end else begin
            dest_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check every accepted destination word
    always @(posedge clk)
    begin
        if (rst_n && dest_valid && !dest_stall) begin
            chk.check_dest_word(dest_word, vertex_end, run_last);
        end
    end

    function automatic logic [WORD_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FORMAT_WIDTH-1:0] rand_mask();
        logic [FORMAT_WIDTH-1:0] a;
        logic [FORMAT_WIDTH-1:0] b;
        a = FORMAT_WIDTH'($urandom);
        b = FORMAT_WIDTH'($urandom);
        case ($urandom_range(0, 3))
            0:       return a & b;
            1:       return a | b;
            2:       return FORMAT_WIDTH'(1) << $urandom_range(0, FORMAT_WIDTH - 1);
            default: return a;
        endcase
    endfunction

    // Offer one source word, idling first at the current rate
    task automatic send_word(input logic [WORD_WIDTH-1:0] w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            source_valid <= 1'b0;
            source_word  <= $urandom;
            @(posedge clk);
        end
        source_valid <= 1'b1;
        source_word  <= w;
        do begin
            @(posedge clk);
        end while (source_stall);
        chk.take_source_word(w);
    endtask

    // Drop valid and wait until the block has drained
    task automatic settle();
        source_valid <= 1'b0;
        @(posedge clk);
        while (chk.words_due.size() > 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [FORMAT_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        chk.write_format(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [FORMAT_WIDTH-1:0] sf;
        logic [FORMAT_WIDTH-1:0] df;
        int                      count;
        int                      n;
        int unsigned             vlen;

        chk          = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        source_valid = 1'b0;
        source_word  = '0;
        dest_stall   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both formats empty after reset: words are consumed silently
        send_word('1);
        settle();

        // Empty source, full destination: each word makes a whole zero vertex
        write_reg(CFG_DEST_FORMAT, 16'hFFFF);
        send_word('0);
        send_word('1);
        settle();

        // Full source, empty destination: nothing comes out
        write_reg(CFG_SOURCE_FORMAT, 16'hFFFF);
        write_reg(CFG_DEST_FORMAT, 16'h0000);
        send_word('1);
        send_word('0);
        settle();

        // Mixed layouts: copies, drops, leading and trailing fills
        write_reg(CFG_SOURCE_FORMAT, 16'h2441);
        write_reg(CFG_DEST_FORMAT, 16'h9C82);
        repeat (10) send_word(rand_word());
        settle();

        // Spare register writes mid-vertex must not restart the vertex
        repeat (3) send_word(rand_word());
        settle();
        write_reg(CFG_SPARE_2, FORMAT_WIDTH'($urandom));
        write_reg(CFG_SPARE_3, FORMAT_WIDTH'($urandom));
        repeat (7) send_word(rand_word());
        settle();

        // Random phases over idle modes and format settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0:       begin src_idle_pct = 0;  stall_pct = 0;  end
                1:       begin src_idle_pct = 84; stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  stall_pct = 84; end
                default: begin src_idle_pct = 36; stall_pct = 36; end
            endcase
            case (p)
                0:       begin sf = 16'h0000;    df = 16'hFFFF;    end
                1:       begin sf = 16'hFFFF;    df = 16'hFFFF;    end
                2:       begin sf = 16'hFFFF;    df = rand_mask(); end
                3:       begin sf = rand_mask(); df = 16'hFFFF;    end
                default: begin sf = rand_mask(); df = rand_mask(); end
            endcase
            while (df == 0) begin
                df = rand_mask();
            end
            write_reg(CFG_SOURCE_FORMAT, sf);
            write_reg(CFG_DEST_FORMAT, df);
            if (p == 5) begin
                write_reg(CFG_SPARE_3, FORMAT_WIDTH'($urandom));
            end
            // Hold the receiver off while the sender keeps offering
            if (p == 0) begin
                hold_req <= hold_req + 1;
            end
            vlen = chk.vertex_len(sf);
            if (vlen == 0) begin
                vlen = 1;
            end
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    n = vlen;
                end else begin
                    n = $urandom_range(1, 3);
                end
                for (int k = 0; k < n && count < ITEMS_PER_PHASE; k++) begin
                    send_word(rand_word());
                    count++;
                end
            end
            settle();
        end

        // Drain and wait out the pipeline
        while (chk.words_due.size() > 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (chk.words_due.size() > 0) begin
            chk.errors += chk.words_due.size();
            $display("%0t: %0d expected dest words never arrived", $time, chk.words_due.size());
        end
        $display("Covered %0d source words, %0d dest words checked, %0d register writes.",
                 chk.words_taken, chk.words_checked, chk.reg_writes);
        $display("Masks ranged from empty to full, with idle, stall and long hold-off phases.");
        if (chk.errors == 0) begin
            $display("vertex_format_repacker_top_test: done, clean");
        end else begin
            $display("vertex_format_repacker_top_test: done, errors");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("vertex_format_repacker_top_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/vrp_pkg.sv
sv/vrp_front.sv
sv/vrp_queue.sv
sv/vrp_back.sv
sv/vertex_format_repacker_top.sv
sv/vrp_checker.sv
sim/vertex_format_repacker_top_test.sv
